// ----- hdl/iwms_pkg.sv -----
// Shared types and constants for the IMU window motion statistics block.
package iwms_pkg;

	localparam int AXIS_W     = 16;
	localparam int FILL_OUT_W = 4;
	localparam int TOTAL_W    = 18;

	typedef struct packed {
		logic signed [AXIS_W-1:0] angle_x;
		logic signed [AXIS_W-1:0] angle_y;
		logic signed [AXIS_W-1:0] angle_z;
		logic signed [AXIS_W-1:0] acc_x;
		logic signed [AXIS_W-1:0] acc_y;
		logic signed [AXIS_W-1:0] acc_z;
	} sample_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WALK = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

endpackage

// ----- hdl/iwms_cell.sv -----
// One history cell: holds a single IMU sample and passes it to its neighbor.
module iwms_cell (
	input  logic             clk,
	input  logic             en,
	input  iwms_pkg::sample_t d,
	output iwms_pkg::sample_t q
);

	iwms_pkg::sample_t sample_q;

	always_ff @(posedge clk) begin
		if (en) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

// ----- hdl/iwms_div.sv -----
// Iterative signed-by-unsigned divider that truncates toward zero, one bit per cycle.
module iwms_div #(
	parameter int SUM_W  = 20,
	parameter int FILL_W = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [SUM_W-1:0]                dividend,
	input  logic [FILL_W-1:0]               divisor,
	output logic                            busy,
	output logic [iwms_pkg::AXIS_W-1:0]     quot
);

	localparam int CNT_W = $clog2(SUM_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic [SUM_W-1:0]  mag_q;
	logic [FILL_W-1:0] rem_q;
	logic [FILL_W-1:0] div_q;
	logic [FILL_W:0]   rem_sh;
	logic [FILL_W:0]   rem_sub;
	logic              ge;
	logic [SUM_W-1:0]  res;

	assign rem_sh  = {rem_q, mag_q[SUM_W-1]};
	assign ge      = rem_sh >= {1'b0, div_q};
	assign rem_sub = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(SUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			mag_q <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			mag_q <= {mag_q[SUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[FILL_W-1:0] : rem_sh[FILL_W-1:0];
		end
	end

	assign res  = neg_q ? (~mag_q + 1'b1) : mag_q;
	assign quot = res[iwms_pkg::AXIS_W-1:0];
	assign busy = cnt_q != '0;

endmodule

// ----- hdl/imu_window_motion_stats_core.sv -----
// Top level of the IMU window motion statistics block.
// Usage: each request on the input channel carries one IMU sample (three angles and three
// accelerations, signed 16-bit). For every request the block returns one result: the mean
// of each acceleration axis over all held samples (truncated toward zero), the Z
// acceleration range and each angle spread over the RECENT_COUNT newest samples, the sum of
// the spreads and the number of samples held (up to HISTORY_DEPTH).
// Samples live in a ring of HISTORY_DEPTH cells. After a sample is taken, the ring rotates
// once around, one cell per cycle, past a single accumulator that gathers sums and extremes.
// Three dividers then work one quotient bit per cycle over the sum width.
// The ring walk and the divider run set the time from one accept to the next (default depth ten).
// in_stall is high while a request is being worked on.
// The result sits in an output register; a new request is accepted while it waits. If the
// receiver still stalls when the next result is ready, the block holds that result back.
// Reset empties the history and drops any pending result.
module imu_window_motion_stats_core #(
	parameter int HISTORY_DEPTH = 10,
	parameter int RECENT_COUNT  = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [iwms_pkg::AXIS_W-1:0] angle_x,
	input  logic signed [iwms_pkg::AXIS_W-1:0] angle_y,
	input  logic signed [iwms_pkg::AXIS_W-1:0] angle_z,
	input  logic signed [iwms_pkg::AXIS_W-1:0] acc_x,
	input  logic signed [iwms_pkg::AXIS_W-1:0] acc_y,
	input  logic signed [iwms_pkg::AXIS_W-1:0] acc_z,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [iwms_pkg::AXIS_W-1:0] avg_acc_x,
	output logic signed [iwms_pkg::AXIS_W-1:0] avg_acc_y,
	output logic signed [iwms_pkg::AXIS_W-1:0] avg_acc_z,
	output logic [iwms_pkg::AXIS_W-1:0]        acc_z_range,
	output logic [iwms_pkg::AXIS_W-1:0]        spread_x,
	output logic [iwms_pkg::AXIS_W-1:0]        spread_y,
	output logic [iwms_pkg::AXIS_W-1:0]        spread_z,
	output logic [iwms_pkg::TOTAL_W-1:0]       spread_total,
	output logic [iwms_pkg::FILL_OUT_W-1:0]    fill_count
);

	localparam int W      = iwms_pkg::AXIS_W;
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W  = W + $clog2(HISTORY_DEPTH);
	localparam int RLIM   = (RECENT_COUNT < HISTORY_DEPTH) ? RECENT_COUNT : HISTORY_DEPTH;
	localparam logic [FILL_W-1:0] RECENT_LIM = FILL_W'(RLIM);
	localparam logic [FILL_W-1:0] DEPTH_FULL = FILL_W'(HISTORY_DEPTH);
	localparam logic [FILL_W-1:0] DEPTH_LAST = FILL_W'(HISTORY_DEPTH - 1);
	localparam logic signed [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] NEG_MAX = {1'b1, {(W-1){1'b0}}};

	iwms_pkg::state_t  state_q;
	iwms_pkg::sample_t in_sample;
	iwms_pkg::sample_t cell_d [HISTORY_DEPTH];
	iwms_pkg::sample_t cell_q [HISTORY_DEPTH];
	iwms_pkg::sample_t tail;

	logic                in_acc;
	logic                cell_en;
	logic                walk_last;
	logic                in_sum;
	logic                in_rec;
	logic                div_start;
	logic                div_busy;
	logic                out_load;
	logic [FILL_W-1:0]   fill_q;
	logic [FILL_W-1:0]   age_q;
	logic [FILL_W+3:0]   fill_ext;

	logic signed [SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic signed [SUM_W-1:0] sum_x_n, sum_y_n, sum_z_n;
	logic signed [W-1:0] amin_x_q, amin_y_q, amin_z_q, zmin_q;
	logic signed [W-1:0] amax_x_q, amax_y_q, amax_z_q, zmax_q;
	logic [W-1:0]        quot_x, quot_y, quot_z;
	logic [W-1:0]        spx, spy, spz, zrng;
	logic                busy_y, busy_z;

	logic                    out_valid_q;
	logic signed [W-1:0]     avg_x_q, avg_y_q, avg_z_q;
	logic [W-1:0]            zrng_q, spx_q, spy_q, spz_q;
	logic [iwms_pkg::TOTAL_W-1:0]    total_q;
	logic [iwms_pkg::FILL_OUT_W-1:0] fill_out_q;

	assign in_stall  = state_q != iwms_pkg::ST_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign cell_en   = in_acc || (state_q == iwms_pkg::ST_WALK);
	assign walk_last = (state_q == iwms_pkg::ST_WALK) && (age_q == '0);
	assign div_start = walk_last;
	assign out_load  = (state_q == iwms_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	assign in_sample = '{angle_x: angle_x, angle_y: angle_y, angle_z: angle_z,
	                     acc_x: acc_x, acc_y: acc_y, acc_z: acc_z};
	assign tail      = cell_q[HISTORY_DEPTH-1];

	always_comb begin
		cell_d[0] = in_acc ? in_sample : tail;
		for (int i = 1; i < HISTORY_DEPTH; i++) begin
			cell_d[i] = cell_q[i-1];
		end
	end

	for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_ring
		iwms_cell u_cell (
			.clk (clk),
			.en  (cell_en),
			.d   (cell_d[g]),
			.q   (cell_q[g])
		);
	end

	assign in_sum  = age_q < fill_q;
	assign in_rec  = in_sum && (age_q < RECENT_LIM);
	assign sum_x_n = sum_x_q + (in_sum ? {{(SUM_W-W){tail.acc_x[W-1]}}, tail.acc_x} : '0);
	assign sum_y_n = sum_y_q + (in_sum ? {{(SUM_W-W){tail.acc_y[W-1]}}, tail.acc_y} : '0);
	assign sum_z_n = sum_z_q + (in_sum ? {{(SUM_W-W){tail.acc_z[W-1]}}, tail.acc_z} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iwms_pkg::ST_IDLE;
			fill_q  <= '0;
			age_q   <= '0;
		end else begin
			case (state_q)
				iwms_pkg::ST_IDLE: begin
					if (in_acc) begin
						state_q <= iwms_pkg::ST_WALK;
						age_q   <= DEPTH_LAST;
						if (fill_q < DEPTH_FULL) begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				iwms_pkg::ST_WALK: begin
					age_q <= age_q - 1'b1;
					if (walk_last) begin
						state_q <= iwms_pkg::ST_DIV;
					end
				end
				iwms_pkg::ST_DIV: begin
					if (!div_busy) begin
						state_q <= iwms_pkg::ST_DONE;
					end
				end
				iwms_pkg::ST_DONE: begin
					if (out_load) begin
						state_q <= iwms_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= iwms_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_z_q  <= '0;
			amin_x_q <= POS_MAX;
			amin_y_q <= POS_MAX;
			amin_z_q <= POS_MAX;
			zmin_q   <= POS_MAX;
			amax_x_q <= NEG_MAX;
			amax_y_q <= NEG_MAX;
			amax_z_q <= NEG_MAX;
			zmax_q   <= NEG_MAX;
		end else if (state_q == iwms_pkg::ST_WALK) begin
			sum_x_q <= sum_x_n;
			sum_y_q <= sum_y_n;
			sum_z_q <= sum_z_n;
			if (in_rec) begin
				if (tail.angle_x < amin_x_q) amin_x_q <= tail.angle_x;
				if (tail.angle_y < amin_y_q) amin_y_q <= tail.angle_y;
				if (tail.angle_z < amin_z_q) amin_z_q <= tail.angle_z;
				if (tail.acc_z < zmin_q) zmin_q <= tail.acc_z;
				if (tail.angle_x > amax_x_q) amax_x_q <= tail.angle_x;
				if (tail.angle_y > amax_y_q) amax_y_q <= tail.angle_y;
				if (tail.angle_z > amax_z_q) amax_z_q <= tail.angle_z;
				if (tail.acc_z > zmax_q) zmax_q <= tail.acc_z;
			end
		end
	end

	iwms_div #(.SUM_W(SUM_W), .FILL_W(FILL_W)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_x_n),
		.divisor  (fill_q),
		.busy     (div_busy),
		.quot     (quot_x)
	);

	iwms_div #(.SUM_W(SUM_W), .FILL_W(FILL_W)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_y_n),
		.divisor  (fill_q),
		.busy     (busy_y),
		.quot     (quot_y)
	);

	iwms_div #(.SUM_W(SUM_W), .FILL_W(FILL_W)) u_div_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_z_n),
		.divisor  (fill_q),
		.busy     (busy_z),
		.quot     (quot_z)
	);

	assign spx      = amax_x_q - amin_x_q;
	assign spy      = amax_y_q - amin_y_q;
	assign spz      = amax_z_q - amin_z_q;
	assign zrng     = zmax_q - zmin_q;
	assign fill_ext = {4'b0000, fill_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			avg_x_q    <= quot_x;
			avg_y_q    <= quot_y;
			avg_z_q    <= quot_z;
			zrng_q     <= zrng;
			spx_q      <= spx;
			spy_q      <= spy;
			spz_q      <= spz;
			total_q    <= {2'b00, spx} + {2'b00, spy} + {2'b00, spz};
			fill_out_q <= fill_ext[iwms_pkg::FILL_OUT_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign avg_acc_x    = avg_x_q;
	assign avg_acc_y    = avg_y_q;
	assign avg_acc_z    = avg_z_q;
	assign acc_z_range  = zrng_q;
	assign spread_x     = spx_q;
	assign spread_y     = spy_q;
	assign spread_z     = spz_q;
	assign spread_total = total_q;
	assign fill_count   = fill_out_q;

`ifndef SYNTHESIS
	a_accept_walks: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == iwms_pkg::ST_WALK)
		else $error("accepted request did not start the ring walk");

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (busy_y && busy_z && state_q == iwms_pkg::ST_DIV))
		else $error("dividers out of step with the controller");

	a_total_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> spread_total == ({2'b00, spread_x} + {2'b00, spread_y}
		                              + {2'b00, spread_z}))
		else $error("spread total does not match the spreads");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_FULL && (state_q == iwms_pkg::ST_IDLE || fill_q != '0))
		else $error("history fill count out of range");
`endif

endmodule

// ----- bench/imu_window_motion_stats_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the IMU window motion statistics core with a scoreboard class.
module imu_window_motion_stats_core_test;

	localparam int HIST_DEPTH   = 10;
	localparam int RECENT_DEPTH = 5;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASE_ITEMS  = 345;
	localparam int DIRECTED_CNT = 20;
	localparam int HOLD_CYCLES  = 400;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic signed [iwms_pkg::AXIS_W-1:0] avg_acc_x;
		logic signed [iwms_pkg::AXIS_W-1:0] avg_acc_y;
		logic signed [iwms_pkg::AXIS_W-1:0] avg_acc_z;
		logic [iwms_pkg::AXIS_W-1:0]        acc_z_range;
		logic [iwms_pkg::AXIS_W-1:0]        spread_x;
		logic [iwms_pkg::AXIS_W-1:0]        spread_y;
		logic [iwms_pkg::AXIS_W-1:0]        spread_z;
		logic [iwms_pkg::TOTAL_W-1:0]       spread_total;
		logic [iwms_pkg::FILL_OUT_W-1:0]    fill_count;
	} motion_stats_t;

	class stats_scoreboard;
		int angle_ring [HIST_DEPTH][3];
		int accel_ring [HIST_DEPTH][3];
		int held;
		int newest;
		int mismatches;
		motion_stats_t expected_q [$];

		function new();
			held = 0;
			newest = 0;
			mismatches = 0;
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		function void note_sample(iwms_pkg::sample_t s);
			int slot, win, k, a, idx, v, quot;
			int sum [3];
			int lo [3];
			int hi [3];
			int spr [3];
			int z_lo, z_hi;
			motion_stats_t e;
			slot = (held == 0) ? 0 : (newest + 1) % HIST_DEPTH;
			angle_ring[slot][0] = $signed(s.angle_x);
			angle_ring[slot][1] = $signed(s.angle_y);
			angle_ring[slot][2] = $signed(s.angle_z);
			accel_ring[slot][0] = $signed(s.acc_x);
			accel_ring[slot][1] = $signed(s.acc_y);
			accel_ring[slot][2] = $signed(s.acc_z);
			newest = slot;
			if (held < HIST_DEPTH) begin
				held++;
			end
			win = (held < RECENT_DEPTH) ? held : RECENT_DEPTH;
			for (a = 0; a < 3; a++) begin
				sum[a] = 0;
				lo[a] = angle_ring[slot][a];
				hi[a] = angle_ring[slot][a];
			end
			z_lo = accel_ring[slot][2];
			z_hi = accel_ring[slot][2];
			for (k = 0; k < held; k++) begin
				idx = (newest + HIST_DEPTH - k) % HIST_DEPTH;
				for (a = 0; a < 3; a++) begin
					sum[a] += accel_ring[idx][a];
				end
				if (k < win) begin
					for (a = 0; a < 3; a++) begin
						v = angle_ring[idx][a];
						if (v < lo[a]) lo[a] = v;
						if (v > hi[a]) hi[a] = v;
					end
					if (accel_ring[idx][2] < z_lo) z_lo = accel_ring[idx][2];
					if (accel_ring[idx][2] > z_hi) z_hi = accel_ring[idx][2];
				end
			end
			for (a = 0; a < 3; a++) begin
				spr[a] = hi[a] - lo[a];
			end
			quot = sum[0] / held;
			e.avg_acc_x = quot[iwms_pkg::AXIS_W-1:0];
			quot = sum[1] / held;
			e.avg_acc_y = quot[iwms_pkg::AXIS_W-1:0];
			quot = sum[2] / held;
			e.avg_acc_z = quot[iwms_pkg::AXIS_W-1:0];
			v = z_hi - z_lo;
			e.acc_z_range = v[iwms_pkg::AXIS_W-1:0];
			e.spread_x = spr[0][iwms_pkg::AXIS_W-1:0];
			e.spread_y = spr[1][iwms_pkg::AXIS_W-1:0];
			e.spread_z = spr[2][iwms_pkg::AXIS_W-1:0];
			v = spr[0] + spr[1] + spr[2];
			e.spread_total = v[iwms_pkg::TOTAL_W-1:0];
			e.fill_count = held[iwms_pkg::FILL_OUT_W-1:0];
			expected_q.push_back(e);
		endfunction

		function void check_result(motion_stats_t got);
			motion_stats_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("%0t: result with no request waiting", $realtime);
				end
				return;
			end
			e = expected_q.pop_front();
			if (got.avg_acc_x !== e.avg_acc_x || got.avg_acc_y !== e.avg_acc_y ||
					got.avg_acc_z !== e.avg_acc_z || got.acc_z_range !== e.acc_z_range ||
					got.spread_x !== e.spread_x || got.spread_y !== e.spread_y ||
					got.spread_z !== e.spread_z || got.spread_total !== e.spread_total ||
					got.fill_count !== e.fill_count) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("%0t: mismatch, expected avg %0d %0d %0d range %0d",
						$realtime, e.avg_acc_x, e.avg_acc_y, e.avg_acc_z, e.acc_z_range,
						" spread %0d %0d %0d total %0d fill %0d",
						e.spread_x, e.spread_y, e.spread_z, e.spread_total, e.fill_count);
					$display("%0t: mismatch, actual   avg %0d %0d %0d range %0d",
						$realtime, got.avg_acc_x, got.avg_acc_y, got.avg_acc_z,
						got.acc_z_range, " spread %0d %0d %0d total %0d fill %0d",
						got.spread_x, got.spread_y, got.spread_z, got.spread_total,
						got.fill_count);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [iwms_pkg::AXIS_W-1:0] angle_x = '0;
	logic signed [iwms_pkg::AXIS_W-1:0] angle_y = '0;
	logic signed [iwms_pkg::AXIS_W-1:0] angle_z = '0;
	logic signed [iwms_pkg::AXIS_W-1:0] acc_x = '0;
	logic signed [iwms_pkg::AXIS_W-1:0] acc_y = '0;
	logic signed [iwms_pkg::AXIS_W-1:0] acc_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [iwms_pkg::AXIS_W-1:0] avg_acc_x;
	logic signed [iwms_pkg::AXIS_W-1:0] avg_acc_y;
	logic signed [iwms_pkg::AXIS_W-1:0] avg_acc_z;
	logic [iwms_pkg::AXIS_W-1:0] acc_z_range;
	logic [iwms_pkg::AXIS_W-1:0] spread_x;
	logic [iwms_pkg::AXIS_W-1:0] spread_y;
	logic [iwms_pkg::AXIS_W-1:0] spread_z;
	logic [iwms_pkg::TOTAL_W-1:0] spread_total;
	logic [iwms_pkg::FILL_OUT_W-1:0] fill_count;

	logic hold_on = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycle_count = 0;
	stats_scoreboard sb;

	imu_window_motion_stats_core #(
		.HISTORY_DEPTH(HIST_DEPTH),
		.RECENT_COUNT(RECENT_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.angle_x(angle_x),
		.angle_y(angle_y),
		.angle_z(angle_z),
		.acc_x(acc_x),
		.acc_y(acc_y),
		.acc_z(acc_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.avg_acc_x(avg_acc_x),
		.avg_acc_y(avg_acc_y),
		.avg_acc_z(avg_acc_z),
		.acc_z_range(acc_z_range),
		.spread_x(spread_x),
		.spread_y(spread_y),
		.spread_z(spread_z),
		.spread_total(spread_total),
		.fill_count(fill_count)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin : result_monitor
		motion_stats_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.avg_acc_x = avg_acc_x;
			got.avg_acc_y = avg_acc_y;
			got.avg_acc_z = avg_acc_z;
			got.acc_z_range = acc_z_range;
			got.spread_x = spread_x;
			got.spread_y = spread_y;
			got.spread_z = spread_z;
			got.spread_total = spread_total;
			got.fill_count = fill_count;
			sb.check_result(got);
		end
		if (hold_on) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic logic signed [iwms_pkg::AXIS_W-1:0] random_axis();
		case ($urandom_range(7))
			0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			1: return $urandom_range(1) ? 16'sh0000 : 16'shffff;
			2, 3: return 16'($urandom_range(16)) - 16'sd8;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic iwms_pkg::sample_t random_sample();
		iwms_pkg::sample_t s;
		s.angle_x = random_axis();
		s.angle_y = random_axis();
		s.angle_z = random_axis();
		s.acc_x = random_axis();
		s.acc_y = random_axis();
		s.acc_z = random_axis();
		return s;
	endfunction

	// The history first fills with mixed extremes and small negatives, then wraps on the minimum.
	function automatic iwms_pkg::sample_t directed_sample(int i);
		iwms_pkg::sample_t s;
		if (i == 0) begin
			s = {6{16'sh7fff}};
		end else if (i == 1 || i >= 10) begin
			s = {6{16'sh8000}};
		end else begin
			s.angle_x = (i % 2) ? 16'sh5555 : 16'shaaaa;
			s.angle_y = ~s.angle_x;
			s.angle_z = 16'(i);
			s.acc_x = -16'(i);
			s.acc_y = 16'(i * 3) - 16'sd13;
			s.acc_z = (i % 2) ? 16'sh7fff : 16'sh8000;
		end
		return s;
	endfunction

	task automatic send_request(iwms_pkg::sample_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		angle_x <= s.angle_x;
		angle_y <= s.angle_y;
		angle_z <= s.angle_z;
		acc_x <= s.acc_x;
		acc_y <= s.acc_y;
		acc_z <= s.acc_z;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_sample(s);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic hold_receiver(int cycles);
		hold_on <= 1'b1;
		repeat (cycles) @(posedge clk);
		hold_on <= 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_CNT; i++) begin
			send_request(directed_sample(i));
		end
		drain_results();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// A long receiver hold-off lets the output back up into the input channel.
				if (phase == 0 && n == 100) begin
					fork
						hold_receiver(HOLD_CYCLES);
					join_none
				end
				send_request(random_sample());
			end
			drain_results();
		end

		repeat (60) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/iwms_pkg.sv
hdl/iwms_cell.sv
hdl/iwms_div.sv
hdl/imu_window_motion_stats_core.sv
bench/imu_window_motion_stats_core_test.sv
